[src/dsmf_pkg.sv]
package dsmf_pkg;

    // Access direction.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register select codes.
    localparam logic [1:0] REG_COMMAND = 2'd0;
    localparam logic [1:0] REG_MTS     = 2'd1;
    localparam logic [1:0] REG_STM     = 2'd2;
    localparam logic [1:0] REG_CONTROL = 2'd3;

    // Accessor codes. The fourth code behaves like the raw side.
    localparam logic [1:0] SIDE_MAIN      = 2'd0;
    localparam logic [1:0] SIDE_SUB       = 2'd1;
    localparam logic [1:0] SIDE_RAW       = 2'd2;
    localparam logic [1:0] SIDE_RAW_ALIAS = 2'd3;

    // Control register constants.
    localparam logic [31:0] CTRL_MAIN_RD_OR = 32'hF000_0102;
    localparam logic [31:0] CTRL_SUB_RD_OR  = 32'hF000_0002;
    localparam logic [15:0] CTRL_SUB_HALF_OR = 16'h0002;
    localparam logic [31:0] CTRL_TOGGLE_MASK = 32'h0000_00F0;
    localparam logic [31:0] CTRL_BIT5       = 32'h0000_0020;
    localparam logic [31:0] CTRL_BIT7       = 32'h0000_0080;
    localparam logic [31:0] CTRL_NIBBLE_CLR = 32'h0000_F000;
    localparam logic [31:0] CTRL_NIBBLE_SET = 32'h0000_2000;
    localparam logic [31:0] CTRL_MAIN_KEEP  = 32'hFFFF_FEFF;
    localparam logic [31:0] CTRL_MAIN_BIT8  = 32'h0000_0100;

    typedef struct packed {
        logic [31:0] command;
        logic [31:0] mts_flags;
        logic [31:0] stm_flags;
        logic [31:0] control;
    } regs_t;

    // Sub-side control update: optional nibble force, then toggle of the bits
    // of 7:4 named by the data as a group, depending on whether any is set.
    function automatic logic [31:0] sub_control(input logic [31:0] cur,
                                                input logic [31:0] data);
        logic [31:0] m;
        logic [31:0] c;
        begin
            m = data & CTRL_TOGGLE_MASK;
            c = cur;
            if (((data & CTRL_BIT5) != '0) || ((data & CTRL_BIT7) != '0)) begin
                c = (c & ~CTRL_NIBBLE_CLR) | CTRL_NIBBLE_SET;
            end
            if ((c & m) != '0) begin
                c = c & ~m;
            end else begin
                c = c | m;
            end
            return c;
        end
    endfunction

endpackage

[src/dual_side_mailbox_flag_registers.sv]
// Dual-side mailbox and flag register file.
//
// Four 32-bit registers (command, main-to-sub flags, sub-to-main flags and
// control) are shared by a main processor, a sub processor and a raw
// accessor. Each item on the s_ channel is one read or write access; each
// produces exactly one item on the m_ channel carrying the read data, which
// is zero for writes and zero-extended for half-word reads.
//
// The access is decoded, the selected register read and its new value
// computed in a single pass of logic; the register file updates at the
// accepting edge and the read data lands in the output register, ready in
// the cycle after acceptance. The next access sees the updated registers,
// so one item is accepted every cycle while the receiver keeps up.
//
// When the receiver stalls, the read data waits in the output register and
// s_ready stays high only if that register is being drained in the same
// cycle; otherwise input is held off until m_ready returns.
//
// Synchronous active-low reset clears all four registers and empties the
// output register.
module dual_side_mailbox_flag_registers (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [1:0]  s_reg_sel,
    input  logic [1:0]  s_side,
    input  logic        s_is_half,
    input  logic        s_half_index,
    input  logic [31:0] s_wdata,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_rdata
);
    import dsmf_pkg::*;

    regs_t       regs_reg;
    regs_t       regs_next;
    logic [31:0] rdata_reg;
    logic [31:0] rdata_next;
    logic        m_valid_reg;
    logic        s_accept;

    // The output register can take a new item when it is empty or being
    // emptied in this cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_rdata  = rdata_reg;

    dsmf_access u_access (
        .op         (s_op),
        .reg_sel    (s_reg_sel),
        .side       (s_side),
        .is_half    (s_is_half),
        .half_index (s_half_index),
        .wdata      (s_wdata),
        .regs_cur   (regs_reg),
        .regs_new   (regs_next),
        .rdata      (rdata_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                regs_reg    <= regs_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Read data carries no reset; it is qualified by m_valid.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rdata_reg <= rdata_next;
        end
    end

endmodule

[src/dsmf_access.sv]
module dsmf_access (
    input  logic                 op,
    input  logic [1:0]           reg_sel,
    input  logic [1:0]           side,
    input  logic                 is_half,
    input  logic                 half_index,
    input  logic [31:0]          wdata,
    input  dsmf_pkg::regs_t      regs_cur,
    output dsmf_pkg::regs_t      regs_new,
    output logic [31:0]          rdata
);
    import dsmf_pkg::*;

    logic [31:0] cur;
    logic [31:0] upd;
    logic [15:0] half_rd;
    logic [31:0] word_rd;
    logic [31:0] sub_lo;
    logic        ctrl_sub_lo;

    assign ctrl_sub_lo = (reg_sel == REG_CONTROL) && (side == SIDE_SUB) && !half_index;

    always_comb begin
        case (reg_sel)
            REG_COMMAND: cur = regs_cur.command;
            REG_MTS:     cur = regs_cur.mts_flags;
            REG_STM:     cur = regs_cur.stm_flags;
            default:     cur = regs_cur.control;
        endcase
    end

    // Read path.
    always_comb begin
        half_rd = half_index ? cur[31:16] : cur[15:0];
        if (ctrl_sub_lo) begin
            half_rd = half_rd | CTRL_SUB_HALF_OR;
        end
        word_rd = cur;
        if (reg_sel == REG_CONTROL) begin
            if (side == SIDE_MAIN) begin
                word_rd = cur | CTRL_MAIN_RD_OR;
            end else if (side == SIDE_SUB) begin
                word_rd = cur | CTRL_SUB_RD_OR;
            end
        end
        if (op == OP_WRITE) begin
            rdata = '0;
        end else if (is_half) begin
            rdata = {16'h0000, half_rd};
        end else begin
            rdata = word_rd;
        end
    end

    // Write path: new value of the selected register.
    always_comb begin
        sub_lo = sub_control({16'h0000, cur[15:0]}, {16'h0000, wdata[15:0]});
        upd    = cur;
        if (is_half) begin
            if (ctrl_sub_lo) begin
                upd = {cur[31:16], sub_lo[15:0]};
            end else if (half_index) begin
                upd = {wdata[15:0], cur[15:0]};
            end else begin
                upd = {cur[31:16], wdata[15:0]};
            end
        end else begin
            case (reg_sel)
                REG_COMMAND: begin
                    if (side != SIDE_SUB) upd = wdata;
                end
                REG_MTS: begin
                    if (side == SIDE_MAIN)     upd = cur | wdata;
                    else if (side == SIDE_SUB) upd = cur & ~wdata;
                    else                       upd = wdata;
                end
                REG_STM: begin
                    if (side == SIDE_MAIN)     upd = cur & ~wdata;
                    else if (side == SIDE_SUB) upd = cur | wdata;
                    else                       upd = wdata;
                end
                default: begin
                    if (side == SIDE_MAIN) begin
                        upd = (cur & CTRL_MAIN_KEEP) | (wdata & CTRL_MAIN_BIT8);
                    end else if (side == SIDE_SUB) begin
                        upd = sub_control(cur, wdata);
                    end else begin
                        upd = wdata;
                    end
                end
            endcase
        end
    end

    always_comb begin
        regs_new = regs_cur;
        if (op == OP_WRITE) begin
            case (reg_sel)
                REG_COMMAND: regs_new.command   = upd;
                REG_MTS:     regs_new.mts_flags = upd;
                REG_STM:     regs_new.stm_flags = upd;
                default:     regs_new.control   = upd;
            endcase
        end
    end

endmodule

[src/dsmf_checker.sv]
module dsmf_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_op,
    input  logic [1:0]  s_reg_sel,
    input  logic [1:0]  s_side,
    input  logic        s_is_half,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_rdata
);
    import dsmf_pkg::*;

    // A result waits until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_rdata))
        else $error("result data changed while stalled");

    // An empty output stage never holds off input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // Every accepted write answers with zero in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_WRITE) |=> m_valid && (m_rdata == '0))
        else $error("write did not return zero");

    // A main-side word read of the control register shows its constant bits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_READ) && (s_reg_sel == REG_CONTROL) &&
        (s_side == SIDE_MAIN) && !s_is_half
        |=> m_valid && ((m_rdata & CTRL_MAIN_RD_OR) == CTRL_MAIN_RD_OR))
        else $error("control read lost constant bits");

endmodule

bind dual_side_mailbox_flag_registers dsmf_checker u_dsmf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_op         (s_op),
    .s_reg_sel    (s_reg_sel),
    .s_side       (s_side),
    .s_is_half    (s_is_half),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_rdata      (m_rdata)
);

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import dsmf_pkg::*;

    // Cycles without any handshake on either channel before the run is declared hung.
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    // Number of random accesses after the directed opening.
    localparam int unsigned NUM_RANDOM = 1100;

    // Constants of the control register, kept separately from the RTL package.
    localparam logic [31:0] CTL_MAIN_READ_BITS = 32'hF000_0102;
    localparam logic [31:0] CTL_SUB_READ_BITS  = 32'hF000_0002;
    localparam logic [31:0] CTL_SUB_HALF_BITS  = 32'h0000_0002;
    localparam logic [31:0] CTL_TOGGLE_FIELD   = 32'h0000_00F0;
    localparam logic [31:0] CTL_FORCE_TRIGGER  = 32'h0000_00A0;
    localparam logic [31:0] CTL_NIBBLE_FIELD   = 32'h0000_F000;
    localparam logic [31:0] CTL_NIBBLE_VALUE   = 32'h0000_2000;
    localparam logic [31:0] CTL_MAIN_BIT       = 32'h0000_0100;

    // One register access as offered on the s_ channel, plus the idle cycles
    // that the sender inserts before offering it and a flag that makes the
    // sender wait for every outstanding result first.
    typedef struct {
        logic        op;
        logic [1:0]  reg_sel;
        logic [1:0]  side;
        logic        is_half;
        logic        half_index;
        logic [31:0] wdata;
        int unsigned gap;
        bit          drain_first;
    } access_t;

    // Predicted read data, tagged with the sequence number of its access.
    typedef struct {
        logic [31:0] rdata;
        int unsigned seq;
    } read_data_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = OP_READ;
    logic [1:0]  s_reg_sel = REG_COMMAND;
    logic [1:0]  s_side = SIDE_MAIN;
    logic        s_is_half = 1'b0;
    logic        s_half_index = 1'b0;
    logic [31:0] s_wdata = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_rdata;

    // Accesses waiting to be offered, and read data still owed by the block.
    access_t     access_q[$];
    read_data_t  read_data_q[$];

    // Mirror of the four registers, indexed by the register select code.
    logic [31:0] mirror_regs [4] = '{default: '0};

    access_t     cur_access;
    bit          access_taken = 1'b0;
    int unsigned gap_left = 0;

    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          long_hold_done = 1'b0;

    int unsigned n_accepted = 0;
    int unsigned n_results = 0;
    int unsigned n_reads = 0;
    int unsigned n_writes = 0;
    int unsigned n_half = 0;
    int unsigned n_sub_ctl_writes = 0;
    int unsigned n_errors = 0;
    int unsigned idle_cycles = 0;

    dual_side_mailbox_flag_registers dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_reg_sel    (s_reg_sel),
        .s_side       (s_side),
        .s_is_half    (s_is_half),
        .s_half_index (s_half_index),
        .s_wdata      (s_wdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_rdata      (m_rdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Sub-side control rule: writing bit 5 or bit 7 forces the nibble at 15:12
    // to 2, then bits 7:4 named by the data are cleared as a group if any of
    // them is already set, or else all set.
    function automatic logic [31:0] sub_ctl_update(input logic [31:0] cur,
                                                   input logic [31:0] data);
        logic [31:0] field;
        logic [31:0] nxt;
        field = data & CTL_TOGGLE_FIELD;
        nxt = cur;
        if ((data & CTL_FORCE_TRIGGER) != '0) begin
            nxt = (nxt & ~CTL_NIBBLE_FIELD) | CTL_NIBBLE_VALUE;
        end
        if ((nxt & field) != '0) begin
            nxt = nxt & ~field;
        end else begin
            nxt = nxt | field;
        end
        return nxt;
    endfunction

    // Applies one access to the register mirror and returns the read data the
    // block owes for it. Writes always return zero.
    function automatic logic [31:0] mailbox_access(input access_t a);
        logic [31:0] cur;
        logic [31:0] rd;
        logic [31:0] hmask;
        logic [31:0] hval;
        logic [31:0] low_next;
        int unsigned sh;
        cur = mirror_regs[a.reg_sel];
        rd = '0;
        sh = a.half_index ? 16 : 0;
        hmask = 32'h0000_FFFF << sh;
        hval = {16'h0000, a.wdata[15:0]};
        if (a.is_half) begin
            n_half++;
        end
        if (a.op == OP_READ) begin
            n_reads++;
            if (a.is_half) begin
                rd = (cur >> sh) & 32'h0000_FFFF;
                if (a.reg_sel == REG_CONTROL && a.side == SIDE_SUB && !a.half_index) begin
                    rd = rd | CTL_SUB_HALF_BITS;
                end
            end else begin
                rd = cur;
                if (a.reg_sel == REG_CONTROL) begin
                    if (a.side == SIDE_MAIN) begin
                        rd = rd | CTL_MAIN_READ_BITS;
                    end else if (a.side == SIDE_SUB) begin
                        rd = rd | CTL_SUB_READ_BITS;
                    end
                end
            end
        end else begin
            n_writes++;
            if (a.reg_sel == REG_CONTROL && a.side == SIDE_SUB) begin
                n_sub_ctl_writes++;
            end
            if (a.is_half) begin
                if (a.reg_sel == REG_CONTROL && a.side == SIDE_SUB && !a.half_index) begin
                    // Only the low half takes part in the sub-side rule here.
                    low_next = sub_ctl_update(cur & 32'h0000_FFFF, hval);
                    cur = (cur & 32'hFFFF_0000) | (low_next & 32'h0000_FFFF);
                end else begin
                    cur = (cur & ~hmask) | (hval << sh);
                end
            end else begin
                case (a.reg_sel)
                    REG_COMMAND: begin
                        if (a.side != SIDE_SUB) begin
                            cur = a.wdata;
                        end
                    end
                    REG_MTS: begin
                        case (a.side)
                            SIDE_MAIN: cur = cur | a.wdata;
                            SIDE_SUB:  cur = cur & ~a.wdata;
                            default:   cur = a.wdata;
                        endcase
                    end
                    REG_STM: begin
                        case (a.side)
                            SIDE_MAIN: cur = cur & ~a.wdata;
                            SIDE_SUB:  cur = cur | a.wdata;
                            default:   cur = a.wdata;
                        endcase
                    end
                    default: begin
                        case (a.side)
                            SIDE_MAIN: cur = (cur & ~CTL_MAIN_BIT) | (a.wdata & CTL_MAIN_BIT);
                            SIDE_SUB:  cur = sub_ctl_update(cur, a.wdata);
                            default:   cur = a.wdata;
                        endcase
                    end
                endcase
            end
            mirror_regs[a.reg_sel] = cur;
        end
        return rd;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        n_errors++;
        $display("[%0t] mismatch: %s, expected %08h, got %08h", $time, what, want, got);
    endtask

    // Queues one access. Most accesses have no idle gap in front of them, some
    // a short one and now and then a long one; a window in the middle of the run has no
    // gaps at all so the block sees back-to-back accesses.
    task automatic queue_access(input logic op, input logic [1:0] reg_sel,
                                input logic [1:0] side, input logic is_half,
                                input logic half_index, input logic [31:0] wdata);
        access_t a;
        int unsigned idx;
        int unsigned r;
        idx = access_q.size();
        a.op = op;
        a.reg_sel = reg_sel;
        a.side = side;
        a.is_half = is_half;
        a.half_index = half_index;
        a.wdata = wdata;
        r = $urandom_range(0, 99);
        if (idx >= 400 && idx < 520) begin
            a.gap = 0;
        end else if (r < 60) begin
            a.gap = 0;
        end else if (r < 92) begin
            a.gap = $urandom_range(1, 3);
        end else begin
            a.gap = $urandom_range(8, 40);
        end
        // Twice in the run the sender stops and lets the block drain fully.
        a.drain_first = (idx == 30 || idx == 700);
        access_q.push_back(a);
    endtask

    // Acceptance on the s_ channel: the mirror is updated at the same edge at
    // which the block takes the item, so the prediction follows the exact
    // order in which accesses enter the block.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            read_data_q.push_back('{rdata: mailbox_access(cur_access), seq: n_accepted});
            n_accepted++;
            access_taken = 1'b1;
        end
    end

    // Driver. A new item is put on the bus at the falling edge only once the
    // previous one has been taken, after its idle gap has run out and, where
    // the item asks for it, after every outstanding result has come back.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (access_taken || !s_valid) begin
                if (access_taken) begin
                    access_taken = 1'b0;
                    gap_left = (access_q.size() != 0) ? access_q[0].gap : 0;
                end
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (access_q.size() != 0 &&
                             !(access_q[0].drain_first && read_data_q.size() != 0)) begin
                    cur_access = access_q.pop_front();
                    s_op <= cur_access.op;
                    s_reg_sel <= cur_access.reg_sel;
                    s_side <= cur_access.side;
                    s_is_half <= cur_access.is_half;
                    s_half_index <= cur_access.half_index;
                    s_wdata <= cur_access.wdata;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure. Once, after 250 results, m_ready is held low
    // while the sender keeps offering, so the output register fills and
    // s_ready has to drop. A later window never stalls at all.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && n_results >= 250) begin
                long_hold_done = 1'b1;
                hold_left = 199;
                m_ready <= 1'b0;
            end else if (n_results >= 600 && n_results < 720) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        stall_left = $urandom_range(0, 2);
                        m_ready <= 1'b0;
                    end
                    2: begin
                        if ($urandom_range(0, 3) == 0) begin
                            stall_left = $urandom_range(8, 40);
                        end
                        m_ready <= 1'b0;
                    end
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    // Monitor: every item on the m_ channel is checked against the oldest
    // prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (read_data_q.size() == 0) begin
                report_mismatch("result with no access outstanding", '0, m_rdata);
            end else if (m_rdata !== read_data_q[0].rdata) begin
                report_mismatch($sformatf("rdata of access %0d", read_data_q[0].seq),
                                read_data_q[0].rdata, m_rdata);
                void'(read_data_q.pop_front());
            end else begin
                void'(read_data_q.pop_front());
            end
        end
    end

    // Watchdog on cycles in which neither channel completes a handshake.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired after %0d idle cycles", idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        logic        r_op;
        logic [1:0]  r_sel;
        logic [1:0]  r_side;
        logic        r_half;
        logic        r_hidx;
        logic [31:0] r_wdata;
        int unsigned pick;

        // Directed opening: reset values of the control read bits for every
        // side, sub writes ignored by the command register, set and clear of
        // both flag registers, the main bit-8-only control write, the sub
        // control nibble force and group toggle in both directions, the sub
        // low-half control rule against a plain high half, and the fourth
        // side code acting like the raw side.
        queue_access(OP_READ,  REG_CONTROL, SIDE_MAIN, 1'b0, 1'b0, 32'h0000_0000);
        queue_access(OP_READ,  REG_CONTROL, SIDE_SUB,  1'b0, 1'b0, 32'hFFFF_FFFF);
        queue_access(OP_READ,  REG_CONTROL, SIDE_RAW,  1'b0, 1'b0, 32'h0000_0000);
        queue_access(OP_READ,  REG_CONTROL, SIDE_SUB,  1'b1, 1'b0, 32'h0000_0000);
        queue_access(OP_WRITE, REG_COMMAND, SIDE_MAIN, 1'b0, 1'b0, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, REG_COMMAND, SIDE_SUB,  1'b0, 1'b0, 32'h0000_0000);
        queue_access(OP_READ,  REG_COMMAND, SIDE_RAW_ALIAS, 1'b0, 1'b0, 32'h0000_0000);
        queue_access(OP_WRITE, REG_MTS,     SIDE_MAIN, 1'b0, 1'b0, 32'hFFFF_0000);
        queue_access(OP_WRITE, REG_MTS,     SIDE_SUB,  1'b0, 1'b0, 32'h0F0F_0F0F);
        queue_access(OP_READ,  REG_MTS,     SIDE_RAW,  1'b1, 1'b1, 32'h0000_0000);
        queue_access(OP_WRITE, REG_STM,     SIDE_SUB,  1'b0, 1'b0, 32'hAAAA_5555);
        queue_access(OP_WRITE, REG_STM,     SIDE_MAIN, 1'b0, 1'b0, 32'h0000_FFFF);
        queue_access(OP_READ,  REG_STM,     SIDE_MAIN, 1'b0, 1'b0, 32'h0000_0000);
        queue_access(OP_WRITE, REG_CONTROL, SIDE_MAIN, 1'b0, 1'b0, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, REG_CONTROL, SIDE_SUB,  1'b0, 1'b0, 32'h0000_00A0);
        queue_access(OP_WRITE, REG_CONTROL, SIDE_SUB,  1'b0, 1'b0, 32'h0000_00F0);
        queue_access(OP_READ,  REG_CONTROL, SIDE_SUB,  1'b0, 1'b0, 32'h0000_0000);
        queue_access(OP_WRITE, REG_CONTROL, SIDE_SUB,  1'b1, 1'b0, 32'hFFFF_0010);
        queue_access(OP_WRITE, REG_CONTROL, SIDE_SUB,  1'b1, 1'b1, 32'h0000_FFFF);
        queue_access(OP_READ,  REG_CONTROL, SIDE_MAIN, 1'b1, 1'b1, 32'h0000_0000);
        queue_access(OP_WRITE, REG_CONTROL, SIDE_RAW,  1'b0, 1'b0, 32'hFFFF_FFFF);
        queue_access(OP_READ,  REG_CONTROL, SIDE_SUB,  1'b1, 1'b0, 32'h0000_0000);
        queue_access(OP_WRITE, REG_COMMAND, SIDE_RAW_ALIAS, 1'b1, 1'b1, 32'h1234_ABCD);
        queue_access(OP_READ,  REG_COMMAND, SIDE_MAIN, 1'b1, 1'b0, 32'h0000_0000);
        queue_access(OP_WRITE, REG_MTS,     SIDE_RAW_ALIAS, 1'b0, 1'b0, 32'h0000_0000);

        // Random accesses. Raw writes keep reloading registers with arbitrary
        // values so that the flag and control rules keep seeing fresh state;
        // data patterns favor the control toggle field and single bits.
        for (int unsigned i = 0; i < NUM_RANDOM; i++) begin
            r_op = 1'($urandom_range(0, 1));
            r_sel = 2'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            r_side = (pick < 30) ? SIDE_MAIN : (pick < 60) ? SIDE_SUB :
                     (pick < 92) ? SIDE_RAW : SIDE_RAW_ALIAS;
            r_half = ($urandom_range(0, 9) < 3);
            r_hidx = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 6))
                0: r_wdata = 32'h0000_0000;
                1: r_wdata = 32'hFFFF_FFFF;
                2: r_wdata = $urandom() & CTL_TOGGLE_FIELD;
                3: r_wdata = 32'h1 << $urandom_range(0, 31);
                4: r_wdata = $urandom() & $urandom();
                default: r_wdata = $urandom();
            endcase
            queue_access(r_op, r_sel, r_side, r_half, r_hidx, r_wdata);
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for the last access to be taken and its result to come back,
        // then let the clock run on so that any stray result from the pipeline
        // would still show.
        while (access_q.size() != 0 || s_valid || read_data_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);

        $display("Covered %0d accesses: %0d reads, %0d writes, %0d half-word,",
                 n_accepted, n_reads, n_writes, n_half);
        $display("  %0d sub control writes", n_sub_ctl_writes);
        $display("Checked %0d results with %0d mismatches", n_results, n_errors);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[files.f]
src/dsmf_pkg.sv
src/dsmf_access.sv
src/dual_side_mailbox_flag_registers.sv
src/dsmf_checker.sv
tb/tb_top.sv
